// ===== rtl/core/pbs_pkg.sv =====
// Package for the power-by-squaring block: sequencer states, binary64 constants
// and small classification helpers.
// No dependencies.
package pbs_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_MUL,
		ST_NORM_L,
		ST_NORM_R,
		ST_ROUND,
		ST_DIV
	} pbs_state_t;

	localparam logic [63:0] F_ONE       = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] F_INF       = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] F_NAN_DFLT  = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] F_QUIET_BIT = 64'h0008_0000_0000_0000;
	localparam logic [10:0] EXP_MAX     = 11'h7FF;

	function automatic logic f_is_nan(input logic [63:0] x);
		return (x[62:52] == EXP_MAX) && (x[51:0] != 52'd0);
	endfunction

	function automatic logic f_is_inf(input logic [63:0] x);
		return (x[62:52] == EXP_MAX) && (x[51:0] == 52'd0);
	endfunction

	function automatic logic f_is_zero(input logic [63:0] x);
		return x[62:0] == 63'd0;
	endfunction

endpackage

// ===== rtl/core/power_by_squaring.sv =====
// Power by square-and-multiply over wrapped 64-bit integers or binary64 values, using pbs_pkg.
// One word at a time: busy stays high from acceptance until the result is strobed on done.
// Kind 0 squares and multiplies on the shared 32x32 multiplier.
// Kind 1 does the same, then normalises and rounds each product, longer with subnormals,
// and a negative exponent adds a reciprocal by long division.
// Reset is asynchronous and returns the sequencer to idle; the receiver cannot stall.
module power_by_squaring (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [63:0] base_bits,
	input  logic [63:0] exponent_bits,
	output logic        done,
	output logic [63:0] power_bits
);

	pbs_pkg::pbs_state_t state_q, state_d;
	logic               kind_q, kind_d;
	logic               neg_q, neg_d;
	logic               phase_q, phase_d;
	logic               dest_q, dest_d;
	logic               prep_q, prep_d;
	logic [63:0]        e_q, e_d;
	logic [63:0]        r_q, r_d;
	logic [63:0]        b_q, b_d;
	logic [63:0]        ma_q, ma_d;
	logic [63:0]        mb_q, mb_d;
	logic [127:0]       acc_q, acc_d;
	logic signed [12:0] ex_q, ex_d;
	logic               sg_q, sg_d;
	logic [5:0]         cnt_q, cnt_d;
	logic [52:0]        mp_q, mp_d;
	logic [53:0]        rem_q, rem_d;
	logic [55:0]        quo_q, quo_d;
	logic               done_q, done_d;
	logic [63:0]        pw_q, pw_d;

	logic [31:0]        mul_x, mul_y;
	logic [63:0]        pp;
	logic [127:0]       pp_ext, acc_sum;
	logic [52:0]        rmant, rmant2;
	logic [53:0]        rsum;
	logic               rup;
	logic signed [12:0] rex2;
	logic [63:0]        rres;
	logic               dge;
	logic [53:0]        drem;
	logic [63:0]        opa;
	logic [10:0]        ea;

	logic               fsp;
	logic [63:0]        fsv;
	pbs_pkg::pbs_state_t fstate;
	logic [63:0]        fa, fb;
	logic [10:0]        fea, feb;
	logic               fmul_start;

	assign mul_x  = cnt_q[0] ? ma_q[63:32] : ma_q[31:0];
	assign mul_y  = cnt_q[1] ? mb_q[63:32] : mb_q[31:0];
	assign pp     = mul_x * mul_y;
	assign pp_ext = (cnt_q[0] & cnt_q[1]) ? {pp, 64'd0} :
		(cnt_q[0] ^ cnt_q[1]) ? {32'd0, pp, 32'd0} : {64'd0, pp};
	assign acc_sum = acc_q + pp_ext;

	assign rmant  = acc_q[105:53];
	assign rup    = acc_q[52] & ((|acc_q[51:0]) | rmant[0]);
	assign rsum   = {1'b0, rmant} + {53'd0, rup};
	assign rmant2 = rsum[53] ? rsum[53:1] : rsum[52:0];
	assign rex2   = rsum[53] ? ex_q + 13'sd1 : ex_q;
	always_comb begin
		if (rex2 > 13'sd2046) begin
			rres = {sg_q, pbs_pkg::F_INF[62:0]};
		end else begin
			rres = {sg_q, (rmant2[52] ? rex2[10:0] : 11'd0), rmant2[51:0]};
		end
	end

	assign dge  = rem_q >= {1'b0, mp_q};
	assign drem = dge ? rem_q - {1'b0, mp_q} : rem_q;

	assign opa = r_q;
	assign ea  = (opa[62:52] == 11'd0) ? 11'd1 : opa[62:52];

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		neg_d   = neg_q;
		phase_d = phase_q;
		dest_d  = dest_q;
		prep_d  = prep_q;
		e_d     = e_q;
		r_d     = r_q;
		b_d     = b_q;
		ma_d    = ma_q;
		mb_d    = mb_q;
		acc_d   = acc_q;
		ex_d    = ex_q;
		sg_d    = sg_q;
		cnt_d   = cnt_q;
		mp_d    = mp_q;
		rem_d   = rem_q;
		quo_d   = quo_q;
		done_d  = 1'b0;
		pw_d    = pw_q;
		case (state_q)
			pbs_pkg::ST_IDLE: begin
				if (start) begin
					kind_d  = kind;
					neg_d   = kind & exponent_bits[63];
					e_d     = (kind & exponent_bits[63]) ? 64'd0 - exponent_bits : exponent_bits;
					r_d     = kind ? pbs_pkg::F_ONE : 64'd1;
					b_d     = base_bits;
					phase_d = 1'b0;
					prep_d  = 1'b0;
					state_d = pbs_pkg::ST_DISPATCH;
				end
			end
			pbs_pkg::ST_DISPATCH: begin
				if (e_q == 64'd0) begin
					if (neg_q) begin
						neg_d  = 1'b0;
						dest_d = 1'b0;
						sg_d   = r_q[63];
						if (pbs_pkg::f_is_zero(r_q)) begin
							r_d = {r_q[63], pbs_pkg::F_INF[62:0]};
						end else if (pbs_pkg::f_is_nan(r_q)) begin
							r_d = r_q | pbs_pkg::F_QUIET_BIT;
						end else if (pbs_pkg::f_is_inf(r_q)) begin
							r_d = {r_q[63], 63'd0};
						end else begin
							acc_d   = {22'd0, (r_q[62:52] != 11'd0), r_q[51:0], 53'd0};
							ex_d    = $signed({2'b00, ea});
							prep_d  = 1'b1;
							state_d = pbs_pkg::ST_NORM_L;
						end
					end else begin
						done_d  = 1'b1;
						pw_d    = r_q;
						state_d = pbs_pkg::ST_IDLE;
					end
				end else if ((!phase_q && e_q[0]) || (phase_q && e_q[63:1] != 63'd0)) begin
					dest_d = phase_q;
					ma_d   = phase_q ? b_q : r_q;
					mb_d   = b_q;
					acc_d  = 128'd0;
					cnt_d  = 6'd0;
					if (phase_q) begin
						e_d = {1'b0, e_q[63:1]};
					end
					phase_d = ~phase_q;
					if (!kind_q) begin
						state_d = pbs_pkg::ST_MUL;
					end
				end else begin
					if (phase_q) begin
						e_d = {1'b0, e_q[63:1]};
					end
					phase_d = ~phase_q;
				end
			end
			pbs_pkg::ST_MUL: begin
				acc_d = acc_sum;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q[1:0] == 2'd3) begin
					if (!kind_q) begin
						if (dest_q) begin
							b_d = acc_sum[63:0];
						end else begin
							r_d = acc_sum[63:0];
						end
						state_d = pbs_pkg::ST_DISPATCH;
					end else begin
						state_d = pbs_pkg::ST_NORM_L;
					end
				end
			end
			pbs_pkg::ST_NORM_L: begin
				if (!acc_q[105]) begin
					acc_d = {acc_q[126:0], 1'b0};
					ex_d  = ex_q - 13'sd1;
				end else if (prep_q) begin
					prep_d  = 1'b0;
					mp_d    = acc_q[105:53];
					ex_d    = 13'sd2046 - ex_q;
					rem_d   = {2'b01, 52'd0};
					quo_d   = 56'd0;
					cnt_d   = 6'd0;
					state_d = pbs_pkg::ST_DIV;
				end else begin
					state_d = pbs_pkg::ST_NORM_R;
				end
			end
			pbs_pkg::ST_NORM_R: begin
				if (ex_q < -13'sd120) begin
					acc_d = {127'd0, |acc_q[105:0]};
					ex_d  = 13'sd1;
				end else if (ex_q < 13'sd1) begin
					acc_d = {1'b0, acc_q[127:2], acc_q[1] | acc_q[0]};
					ex_d  = ex_q + 13'sd1;
				end else begin
					state_d = pbs_pkg::ST_ROUND;
				end
			end
			pbs_pkg::ST_ROUND: begin
				if (dest_q) begin
					b_d = rres;
				end else begin
					r_d = rres;
				end
				state_d = pbs_pkg::ST_DISPATCH;
			end
			pbs_pkg::ST_DIV: begin
				rem_d = {drem[52:0], 1'b0};
				quo_d = {quo_q[54:0], dge};
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd55) begin
					acc_d   = {22'd0, quo_q[54:0], dge, (drem != 54'd0), 49'd0};
					state_d = pbs_pkg::ST_NORM_L;
				end
			end
			default: begin
				state_d = pbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbs_pkg::ST_IDLE;
			done_q  <= 1'b0;
			neg_q   <= 1'b0;
			prep_q  <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			state_q <= fstate;
			done_q  <= done_d;
			neg_q   <= neg_d;
			prep_q  <= prep_d;
			phase_q <= phase_d;
		end
	end

	// Special operands of a binary64 product are settled at once; ordinary ones
	// load the mantissas into the shared multiplier.
	assign fa  = dest_d ? b_q : r_q;
	assign fb  = b_q;
	assign fea = (fa[62:52] == 11'd0) ? 11'd1 : fa[62:52];
	assign feb = (fb[62:52] == 11'd0) ? 11'd1 : fb[62:52];

	always_comb begin
		fsp = 1'b1;
		if (pbs_pkg::f_is_nan(fa)) begin
			fsv = fa | pbs_pkg::F_QUIET_BIT;
		end else if (pbs_pkg::f_is_nan(fb)) begin
			fsv = fb | pbs_pkg::F_QUIET_BIT;
		end else if ((pbs_pkg::f_is_inf(fa) && pbs_pkg::f_is_zero(fb))
			|| (pbs_pkg::f_is_zero(fa) && pbs_pkg::f_is_inf(fb))) begin
			fsv = pbs_pkg::F_NAN_DFLT;
		end else if (pbs_pkg::f_is_inf(fa) || pbs_pkg::f_is_inf(fb)) begin
			fsv = {fa[63] ^ fb[63], pbs_pkg::F_INF[62:0]};
		end else if (pbs_pkg::f_is_zero(fa) || pbs_pkg::f_is_zero(fb)) begin
			fsv = {fa[63] ^ fb[63], 63'd0};
		end else begin
			fsv = 64'd0;
			fsp = 1'b0;
		end
	end

	assign fmul_start = (state_q == pbs_pkg::ST_DISPATCH) && kind_q && (e_q != 64'd0)
		&& ((!phase_q && e_q[0]) || (phase_q && e_q[63:1] != 63'd0));

	always_comb begin
		fstate = state_d;
		if (fmul_start) begin
			fstate = fsp ? pbs_pkg::ST_DISPATCH : pbs_pkg::ST_MUL;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		dest_q <= dest_d;
		e_q    <= e_d;
		acc_q  <= acc_d;
		cnt_q  <= cnt_d;
		mp_q   <= mp_d;
		rem_q  <= rem_d;
		quo_q  <= quo_d;
		pw_q   <= pw_d;
		if (fmul_start) begin
			ma_q <= {11'd0, (fa[62:52] != 11'd0), fa[51:0]};
			mb_q <= {11'd0, (fb[62:52] != 11'd0), fb[51:0]};
			ex_q <= $signed({2'b00, fea}) + $signed({2'b00, feb}) - 13'sd1022;
			sg_q <= fa[63] ^ fb[63];
			if (fsp && dest_d) begin
				b_q <= fsv;
				r_q <= r_d;
			end else if (fsp) begin
				r_q <= fsv;
				b_q <= b_d;
			end else begin
				r_q <= r_d;
				b_q <= b_d;
			end
		end else begin
			ma_q <= ma_d;
			mb_q <= mb_d;
			ex_q <= ex_d;
			sg_q <= sg_d;
			r_q  <= r_d;
			b_q  <= b_d;
		end
	end

	assign busy       = state_q != pbs_pkg::ST_IDLE;
	assign done       = done_q;
	assign power_bits = pw_q;

`ifndef NO_ASSERTIONS
	a_done_from_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == pbs_pkg::ST_DISPATCH)
		else $error("result strobed outside dispatch");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not make the block busy");
	a_mul_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pbs_pkg::ST_MUL |-> cnt_q[5:2] == 4'd0)
		else $error("multiplier step count out of range");
	a_div_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pbs_pkg::ST_DIV |-> mp_q[52])
		else $error("divisor not normalised");
`endif

endmodule

// ===== tb/power_by_squaring_test.sv =====
// Self-checking testbench for power_by_squaring: a directed table, then random words.
// Depends on pbs_pkg for the binary64 constants; results are checked against
// an internal square-and-multiply predictor, built on the simulator's real type for binary64.
module power_by_squaring_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  WATCHDOG_LIMIT = 200000;
	localparam int  RANDOM_WORDS   = 480;
	localparam bit  KIND_INT       = 1'b0;
	localparam bit  KIND_FLOAT     = 1'b1;

	typedef struct {
		bit          kind;
		logic [63:0] base;
		logic [63:0] exponent;
		bit          fixed;
		logic [63:0] power;
	} power_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        kind = 1'b0;
	logic [63:0] base_bits = '0;
	logic [63:0] exponent_bits = '0;
	logic        busy;
	logic        done;
	logic [63:0] power_bits;

	logic [63:0] expected_powers[$];
	int          mismatches = 0;
	int          powers_checked = 0;
	int          int_words = 0;
	int          float_words = 0;
	int          idle_cycles = 0;
	bit          quiet = 1'b0;

	power_by_squaring dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.base_bits(base_bits),
		.exponent_bits(exponent_bits),
		.done(done),
		.power_bits(power_bits)
	);

	always #6 clk = ~clk;

	function automatic logic [63:0] wrapped_power(logic [63:0] b, logic [63:0] e);
		logic [63:0] r;
		r = 64'd1;
		while (e != 64'd0) begin
			if (e[0])
				r = r * b;
			b = b * b;
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic real real_power(real b, logic [63:0] e);
		real r;
		r = 1.0;
		while (e != 64'd0) begin
			if (e[0])
				r = r * b;
			b = b * b;
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic logic [63:0] predict_power(bit k, logic [63:0] b, logic [63:0] e);
		logic [63:0] p;
		if (k == KIND_INT)
			return wrapped_power(b, e);
		if (!e[63])
			return $realtobits(real_power($bitstoreal(b), e));
		p = $realtobits(real_power($bitstoreal(b), -e));
		if (p[62:0] == 63'd0)
			return {p[63], 63'd0} | pbs_pkg::F_INF;
		return $realtobits(1.0 / $bitstoreal(p));
	endfunction

	// Acceptances and results are both seen here, on values from before the edge.
	always @(posedge clk) begin
		if (start && !busy && arst_n) begin
			expected_powers.push_back(predict_power(kind, base_bits, exponent_bits));
			if (kind == KIND_INT)
				int_words++;
			else
				float_words++;
		end
		if (done) begin
			if (expected_powers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result word %h with nothing outstanding.", power_bits);
			end else begin
				if (power_bits !== expected_powers[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Power mismatch: expected %h, got %h.",
							expected_powers[0], power_bits);
				end
				void'(expected_powers.pop_front());
				powers_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding.", expected_powers.size());
			$display("power_by_squaring regression: fail");
			$finish;
		end
	end

	task automatic send_word(bit k, logic [63:0] b, logic [63:0] e);
		while (!quiet && $urandom_range(99) < 10) begin
			start <= 1'b0;
			@(posedge clk);
		end
		kind <= k;
		base_bits <= b;
		exponent_bits <= e;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
	endtask

	function automatic logic [63:0] random_base(bit k);
		case ($urandom_range(5))
			0: return {$urandom, $urandom};
			1: return 64'($urandom_range(9)) - 64'd4;
			2: begin
				case ($urandom_range(5))
					0: return pbs_pkg::F_INF;
					1: return pbs_pkg::F_INF | 64'h8000_0000_0000_0000;
					2: return pbs_pkg::F_INF | pbs_pkg::F_QUIET_BIT | 64'($urandom);
					3: return {1'($urandom_range(1)), 63'd0};
					4: return {1'($urandom_range(1)), 11'd0, 20'($urandom), $urandom};
					default: return pbs_pkg::F_ONE;
				endcase
			end
			default: begin
				if (k == KIND_INT)
					return 64'($urandom_range(65535));
				return {1'($urandom_range(1)), 11'($urandom_range(16'h3FC, 16'h403)),
					20'($urandom), $urandom};
			end
		endcase
	endfunction

	function automatic logic [63:0] random_exponent(bit k);
		case ($urandom_range(9))
			0: return {$urandom, $urandom};
			1: return 64'd0;
			2: return 64'($urandom_range(2000));
			3: return k ? -64'($urandom_range(40)) : {$urandom, $urandom};
			default: return 64'($urandom_range(40));
		endcase
	endfunction

	power_row_t directed[] = '{
		'{KIND_INT, 64'd12345, 64'd0, 1'b1, 64'd1},
		'{KIND_INT, 64'd0, 64'd5, 1'b1, 64'd0},
		'{KIND_INT, '1, '1, 1'b1, '1},
		'{KIND_INT, 64'd2, 64'd63, 1'b1, 64'h8000_0000_0000_0000},
		'{KIND_INT, 64'd2, 64'd64, 1'b1, 64'd0},
		'{KIND_INT, 64'd3, 64'd1, 1'b1, 64'd3},
		'{KIND_INT, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
		'{KIND_INT, 64'h0123_4567_89AB_CDEF, 64'd37, 1'b0, 64'd0},
		'{KIND_FLOAT, pbs_pkg::F_INF | 64'd1, 64'd0, 1'b1, pbs_pkg::F_ONE},
		'{KIND_FLOAT, 64'h4000_0000_0000_0000, 64'd3, 1'b1, 64'h4020_0000_0000_0000},
		'{KIND_FLOAT, 64'h4000_0000_0000_0000, '1, 1'b1, 64'h3FE0_0000_0000_0000},
		'{KIND_FLOAT, 64'd0, '1, 1'b1, pbs_pkg::F_INF},
		'{KIND_FLOAT, 64'h8000_0000_0000_0000, '1, 1'b1, 64'hFFF0_0000_0000_0000},
		'{KIND_FLOAT, 64'h8000_0000_0000_0000, -64'd2, 1'b1, pbs_pkg::F_INF},
		'{KIND_FLOAT, 64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1, 64'd0},
		'{KIND_FLOAT, pbs_pkg::F_ONE, 64'h8000_0000_0000_0000, 1'b1, pbs_pkg::F_ONE},
		'{KIND_FLOAT, pbs_pkg::F_INF, 64'd1, 1'b1, pbs_pkg::F_INF},
		'{KIND_FLOAT, 64'h4000_0000_0000_0000, 64'd1024, 1'b1, pbs_pkg::F_INF},
		'{KIND_FLOAT, 64'h3FE0_0000_0000_0000, 64'd1100, 1'b1, 64'd0},
		'{KIND_FLOAT, 64'd1, 64'd1, 1'b1, 64'd1},
		'{KIND_FLOAT, 64'd1, 64'd2, 1'b1, 64'd0},
		'{KIND_FLOAT, pbs_pkg::F_NAN_DFLT, 64'd1, 1'b0, 64'd0},
		'{KIND_FLOAT, 64'h7FEF_FFFF_FFFF_FFFF, '1, 1'b0, 64'd0},
		'{KIND_FLOAT, 64'hBFF0_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
		'{KIND_FLOAT, 64'h0000_0000_0000_0003, -64'd3, 1'b0, 64'd0}
	};

	initial begin
		bit k;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			if (directed[i].fixed && predict_power(directed[i].kind, directed[i].base,
					directed[i].exponent) !== directed[i].power) begin
				mismatches++;
				$display("Table row %0d disagrees with the predictor.", i);
			end
			send_word(directed[i].kind, directed[i].base, directed[i].exponent);
		end
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			quiet = (n >= 200 && n < 350);
			if (n == 100) begin
				start <= 1'b0;
				while (expected_powers.size() != 0)
					@(posedge clk);
			end
			k = 1'($urandom_range(1));
			send_word(k, random_base(k), random_exponent(k));
		end
		start <= 1'b0;
		while (expected_powers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d integer and %0d binary64 words, %0d results checked.",
			int_words, float_words, powers_checked);
		if (mismatches == 0)
			$display("power_by_squaring regression: pass");
		else
			$display("power_by_squaring regression: fail");
		$finish;
	end

endmodule

// ===== power_by_squaring.f =====
rtl/core/pbs_pkg.sv
rtl/core/power_by_squaring.sv
tb/power_by_squaring_test.sv
